[src/keyed_deque_with_search_defines.svh]
// ----------------------------------------------------------------------------
// Keyed deque assertion macros
// Shared assertion wrappers; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KEYED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define KEYED_DEQUE_WITH_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define KDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define KDQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KDQ_ASSERT(lbl, prop, msg)
`define KDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/kdq_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed deque package
// Sizes, operation and status codes, and the ring slot helper.
// ----------------------------------------------------------------------------
`default_nettype none

package kdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int OP_W     = 3;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int OCC_W    = 5;

	localparam int IN_BITS  = OP_W + KEY_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STATUS_W + POS_W + KEY_W + OCC_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd3;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [KEY_W-1:0] data;
	} wr_req_t;

	// Ring slot of the entry at offset off from the front; the sum stays
	// below twice the depth, so one compare and subtract wraps it.
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(front) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

endpackage

`default_nettype wire

[src/kdq_store.sv]
// ----------------------------------------------------------------------------
// Keyed deque entry store
// Ring storage of keys: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module kdq_store (
	input  wire logic                          clk,
	input  wire kdq_pkg::wr_req_t              wr,
	input  wire logic [kdq_pkg::IDX_W-1:0]     rd_addr,
	output logic      [kdq_pkg::KEY_W-1:0]     rd_data
);

	logic [kdq_pkg::KEY_W-1:0] mem [kdq_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[src/keyed_deque_with_search.sv]
// ----------------------------------------------------------------------------
// Keyed deque with search
// Bounded double-ended queue of 32-bit keys with a linear key search.
// ----------------------------------------------------------------------------
// Each request carries an operation (push back, push front, pop front, pop
// back, search) and a key, and yields exactly one result. The block takes one
// request at a time: a push or unused code runs the execute and done states, a
// pop that finds an entry adds a read state, and a search a scan state
// ending on a hit or after all N entries held; a single comparator walks the
// ring one entry per cycle via the store's read port. A finished result sits
// in the output register, so the next request may be accepted while it waits.
`default_nettype none

`include "keyed_deque_with_search_defines.svh"

module keyed_deque_with_search (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// [2:0] op, [34:3] key, rest zero
	input  wire logic [kdq_pkg::IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [1:0] status, [5:2] position, [37:6] popped_key, [42:38] occupancy
	output logic      [kdq_pkg::OUT_W-1:0]  m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POPRD,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [kdq_pkg::OP_W-1:0]        op_q;
	logic [kdq_pkg::KEY_W-1:0]       key_q;
	logic [kdq_pkg::IDX_W-1:0]       front_q;
	logic [kdq_pkg::CNT_W-1:0]       count_q;
	logic [kdq_pkg::CNT_W-1:0]       rd_q;
	logic                            cmp_v_q;
	logic [kdq_pkg::IDX_W-1:0]       cmp_idx_q;
	logic [kdq_pkg::STATUS_W-1:0]    res_status_q;
	logic [kdq_pkg::POS_W-1:0]       res_pos_q;
	logic [kdq_pkg::KEY_W-1:0]       res_pop_q;
	logic                            m_tvalid_q;
	logic [kdq_pkg::OUT_W-1:0]       m_tdata_q;

	kdq_pkg::wr_req_t                wr;
	logic [kdq_pkg::CNT_W-1:0]       off;
	logic [kdq_pkg::IDX_W-1:0]       slot;
	logic [kdq_pkg::IDX_W-1:0]       front_dec;
	logic [kdq_pkg::KEY_W-1:0]       rd_data;
	logic                            full;
	logic                            empty;
	logic                            hit;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign full  = (count_q == kdq_pkg::CNT_W'(kdq_pkg::DEPTH));
	assign empty = (count_q == '0);
	assign hit   = cmp_v_q && (rd_data == key_q);

	assign front_dec = (front_q == '0) ? kdq_pkg::IDX_W'(kdq_pkg::DEPTH - 1)
		: front_q - kdq_pkg::IDX_W'(1);

	// One slot adder serves all but push front, chosen by what is running.
	always_comb begin
		off = '0;
		if (state_q == ST_SCAN) begin
			off = rd_q;
		end else begin
			case (op_q)
				kdq_pkg::OP_PUSH_BACK: off = count_q;
				kdq_pkg::OP_POP_FRONT: off = kdq_pkg::CNT_W'(1);
				kdq_pkg::OP_POP_BACK:  off = count_q - kdq_pkg::CNT_W'(1);
				default:               off = '0;
			endcase
		end
	end

	assign slot = kdq_pkg::slot_of(front_q, off);

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = slot;
		wr.data = key_q;
		if (state_q == ST_EXEC && !full) begin
			if (op_q == kdq_pkg::OP_PUSH_BACK) begin
				wr.en = 1'b1;
			end else if (op_q == kdq_pkg::OP_PUSH_FRONT) begin
				wr.en   = 1'b1;
				wr.addr = front_dec;
			end
		end
	end

	kdq_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr ((state_q == ST_EXEC && op_q == kdq_pkg::OP_POP_FRONT) ? front_q : slot),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= '0;
			key_q        <= '0;
			front_q      <= '0;
			count_q      <= '0;
			rd_q         <= '0;
			cmp_v_q      <= 1'b0;
			cmp_idx_q    <= '0;
			res_status_q <= kdq_pkg::STAT_OK;
			res_pos_q    <= '0;
			res_pop_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// In the done state the result register is handled below.
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[kdq_pkg::OP_W-1:0];
						key_q   <= s_tdata[kdq_pkg::IN_BITS-1:kdq_pkg::OP_W];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_pos_q <= '0;
					res_pop_q <= '0;
					case (op_q)
						kdq_pkg::OP_PUSH_BACK: begin
							state_q <= ST_DONE;
							if (full) begin
								res_status_q <= kdq_pkg::STAT_FULL;
							end else begin
								res_status_q <= kdq_pkg::STAT_OK;
								count_q      <= count_q + kdq_pkg::CNT_W'(1);
							end
						end
						kdq_pkg::OP_PUSH_FRONT: begin
							state_q <= ST_DONE;
							if (full) begin
								res_status_q <= kdq_pkg::STAT_FULL;
							end else begin
								res_status_q <= kdq_pkg::STAT_OK;
								front_q      <= front_dec;
								count_q      <= count_q + kdq_pkg::CNT_W'(1);
							end
						end
						kdq_pkg::OP_POP_FRONT: begin
							if (empty) begin
								res_status_q <= kdq_pkg::STAT_EMPTY;
								state_q      <= ST_DONE;
							end else begin
								res_status_q <= kdq_pkg::STAT_OK;
								front_q      <= slot;
								count_q      <= count_q - kdq_pkg::CNT_W'(1);
								state_q      <= ST_POPRD;
							end
						end
						kdq_pkg::OP_POP_BACK: begin
							if (empty) begin
								res_status_q <= kdq_pkg::STAT_EMPTY;
								state_q      <= ST_DONE;
							end else begin
								res_status_q <= kdq_pkg::STAT_OK;
								count_q      <= count_q - kdq_pkg::CNT_W'(1);
								state_q      <= ST_POPRD;
							end
						end
						kdq_pkg::OP_SEARCH: begin
							rd_q    <= '0;
							cmp_v_q <= 1'b0;
							state_q <= ST_SCAN;
						end
						default: begin
							res_status_q <= kdq_pkg::STAT_OK;
							state_q      <= ST_DONE;
						end
					endcase
				end
				ST_POPRD: begin
					res_pop_q <= rd_data;
					state_q   <= ST_DONE;
				end
				ST_SCAN: begin
					// Reads run one entry ahead of the compare.
					if (hit) begin
						res_status_q <= kdq_pkg::STAT_OK;
						res_pos_q    <= kdq_pkg::POS_W'(cmp_idx_q);
						cmp_v_q      <= 1'b0;
						state_q      <= ST_DONE;
					end else if (rd_q == count_q) begin
						res_status_q <= kdq_pkg::STAT_MISS;
						res_pos_q    <= '0;
						cmp_v_q      <= 1'b0;
						state_q      <= ST_DONE;
					end else begin
						cmp_v_q   <= 1'b1;
						cmp_idx_q <= kdq_pkg::IDX_W'(rd_q);
						rd_q      <= rd_q + kdq_pkg::CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= kdq_pkg::OUT_W'({kdq_pkg::OCC_W'(count_q), res_pop_q,
							res_pos_q, res_status_q});
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`KDQ_ASSERT_ALWAYS(a_count_bound, count_q <= kdq_pkg::CNT_W'(kdq_pkg::DEPTH),
		"count beyond depth")
	`KDQ_ASSERT(a_accept_exec, s_tvalid && s_tready |=> state_q == ST_EXEC, "accept did not start")
	`KDQ_ASSERT(a_count_step, count_q == $past(count_q) || count_q == $past(count_q) + 1
		|| count_q + 1 == $past(count_q), "count jumped")
	`KDQ_ASSERT(a_result_src, $rose(m_tvalid) |-> $past(state_q) == ST_DONE,
		"result out of order")
	`KDQ_ASSERT(a_scan_bound, state_q == ST_SCAN |-> rd_q <= count_q, "scan past occupancy")

endmodule

`default_nettype wire
